// ===== rtl/ldc_pkg.sv =====
// ----------------------------------------------------------------------------
// ldc_pkg
// Shared types and constants of the linear discriminant classifier.
// ----------------------------------------------------------------------------
package ldc_pkg;

    localparam int CLASSES  = 8;
    localparam int FEATURES = 64;

    localparam int FEAT_AW = $clog2(FEATURES);
    localparam int CLS_IW  = $clog2(CLASSES);
    localparam int CLS_CW  = $clog2(CLASSES + 1);

    localparam int VAL_W   = 16;
    localparam int BIAS_W  = 32;
    localparam int LABEL_W = 16;
    localparam int ACC_W   = 40;
    localparam int PROD_W  = 2 * VAL_W;

    typedef enum logic [1:0] {
        CMD_WEIGHT  = 2'd0,
        CMD_BIAS    = 2'd1,
        CMD_FEATURE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_MODEL_READY    = 2'd0,
        CFG_ACTIVE_CLASSES = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEAT,
        S_ARG,
        S_PUSH
    } t_state;

    // Feature item travelling down the chain.
    typedef struct packed {
        logic                    vld;
        logic                    seed;
        logic [FEAT_AW-1:0]      addr;
        logic signed [VAL_W-1:0] value;
    } t_feat_tok;

    // Running argmax travelling down the chain.
    typedef struct packed {
        logic                      vld;
        logic [CLS_CW-1:0]         cur;
        logic [CLS_CW-1:0]         num;
        logic [CLS_IW-1:0]         idx;
        logic signed [ACC_W-1:0]   score;
        logic signed [LABEL_W-1:0] label;
    } t_best_tok;

    // Load bus shared by all cells.
    typedef struct packed {
        logic [FEAT_AW-1:0]        addr;
        logic signed [VAL_W-1:0]   weight;
        logic signed [BIAS_W-1:0]  bias;
        logic signed [LABEL_W-1:0] label;
    } t_load_bus;

endpackage

// ===== rtl/linear_discriminant_classifier_top.sv =====
// ----------------------------------------------------------------------------
// linear_discriminant_classifier_top
// Linear discriminant classifier, inference side, built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis takes load and feature items (tuser = cmd, tdata fields below,
//   tlast = last feature of a sample). A feature item walks the row of
//   CLASSES cells, one hop a cycle, each cell reading its weight,
//   multiplying and accumulating; no new item is taken until the
//   feature run is over. On the last feature a running argmax then walks
//   the same row; its result is held in a result register and moves to
//   the m_axis output register once that register is free. One item at
//   a time.
//   The cfg channel (index, data) is always ready: index 0 model_ready,
//   index 1 active_classes; write it only while the block is idle.
//   Feature items are dropped while model_ready is clear.
//   Reset clears control state, model_ready=0 and active_classes=2;
//   weights, biases and labels must be loaded before use.
//   A stalled m_axis receiver holds the result in the output register;
//   new items are still taken until a further result needs the register.
// ----------------------------------------------------------------------------
module linear_discriminant_classifier_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // class_index[2:0], feature_index[8:3], value[24:9],
    // bias_value[56:25], class_label[72:57], zero[79:73]
    input  logic [79:0] i_s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tlast,
    output logic        o_s_axis_tready,
    // predicted_label[15:0], winning_class[18:16], winning_score[58:19],
    // zero[63:59]
    output logic [63:0] o_m_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    import ldc_pkg::*;

    localparam int FEAT_LAT = CLASSES + 3;
    localparam int CNT_W    = $clog2(FEAT_LAT);

    t_state                    r_state;
    t_state                    n_state;
    logic [CNT_W-1:0]          r_cnt;
    logic [CNT_W-1:0]          n_cnt;
    logic                      r_started;
    logic                      n_started;
    logic                      r_last;
    logic                      r_model_ready;
    logic [3:0]                r_active;
    logic [CLS_CW-1:0]         w_num;

    logic                      w_in_acc;
    logic                      w_out_free;
    t_cmd                      w_cmd;
    logic [2:0]                w_class;
    t_load_bus                 w_load;
    logic [CLASSES-1:0]        w_we;
    logic [CLASSES-1:0]        w_be;

    t_feat_tok                 r_tok;
    t_feat_tok                 n_tok;
    t_best_tok                 r_launch;
    t_best_tok                 n_launch;
    t_feat_tok                 w_feat [CLASSES+1];
    t_best_tok                 w_best [CLASSES+1];

    logic [CLS_IW-1:0]         r_res_idx;
    logic signed [ACC_W-1:0]   r_res_score;
    logic signed [LABEL_W-1:0] r_res_label;
    logic                      r_out_vld;
    logic [2:0]                r_out_cls;
    logic signed [ACC_W-1:0]   r_out_score;
    logic signed [LABEL_W-1:0] r_out_label;
    logic                      w_out_load;

    assign w_in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free  = !r_out_vld || i_m_axis_tready;
    assign w_cmd       = t_cmd'(i_s_axis_tuser);
    assign w_class     = i_s_axis_tdata[2:0];
    assign w_load.addr   = FEAT_AW'(i_s_axis_tdata[8:3]);
    assign w_load.weight = i_s_axis_tdata[24:9];
    assign w_load.bias   = i_s_axis_tdata[56:25];
    assign w_load.label  = i_s_axis_tdata[72:57];

    always_comb begin
        if (r_active == '0) begin
            w_num = CLS_CW'(1);
        end else if (32'(r_active) > CLASSES) begin
            w_num = CLS_CW'(CLASSES);
        end else begin
            w_num = CLS_CW'(r_active);
        end
    end

    always_comb begin
        for (int k = 0; k < CLASSES; k++) begin
            w_we[k] = w_in_acc && (w_cmd == CMD_WEIGHT) && (32'(w_class) == k);
            w_be[k] = w_in_acc && (w_cmd == CMD_BIAS) && (32'(w_class) == k);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_started    = r_started;
        n_tok        = '0;
        n_launch     = '0;
        w_out_load   = 1'b0;
        n_tok.addr   = w_load.addr;
        n_tok.value  = w_load.weight;
        n_tok.seed   = !r_started;
        n_launch.num = w_num;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_cmd == CMD_FEATURE && r_model_ready) begin
                    n_tok.vld = 1'b1;
                    n_started = !i_s_axis_tlast;
                    n_cnt     = '0;
                    n_state   = S_FEAT;
                end
            end
            S_FEAT: begin
                n_cnt = r_cnt + 1'b1;
                if (32'(r_cnt) == FEAT_LAT - 1) begin
                    if (r_last) begin
                        n_launch.vld = 1'b1;
                        n_state      = S_ARG;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ARG: begin
                if (w_best[CLASSES].vld) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= '0;
            r_started     <= 1'b0;
            r_tok         <= '0;
            r_launch      <= '0;
            r_out_vld     <= 1'b0;
            r_model_ready <= 1'b0;
            r_active      <= 4'd2;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_started <= n_started;
            r_tok     <= n_tok;
            r_launch  <= n_launch;
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MODEL_READY:    r_model_ready <= i_cfg_data[0];
                    CFG_ACTIVE_CLASSES: r_active      <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_acc) begin
            r_last <= i_s_axis_tlast;
        end
        if (w_best[CLASSES].vld) begin
            r_res_idx   <= w_best[CLASSES].idx;
            r_res_score <= w_best[CLASSES].score;
            r_res_label <= w_best[CLASSES].label;
        end
        if (w_out_load) begin
            r_out_cls   <= 3'(r_res_idx);
            r_out_score <= r_res_score;
            r_out_label <= r_res_label;
        end
    end

    assign w_feat[0] = r_tok;
    assign w_best[0] = r_launch;

    for (genvar g = 0; g < CLASSES; g++) begin : g_cell
        ldc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_we    (w_we[g]),
            .i_be    (w_be[g]),
            .i_load  (w_load),
            .i_feat  (w_feat[g]),
            .o_feat  (w_feat[g+1]),
            .i_best  (w_best[g]),
            .o_best  (w_best[g+1])
        );
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {5'b0, r_out_score, r_out_cls, r_out_label};
    assign o_cfg_ready     = 1'b1;

`ifndef SYNTHESIS
    a_best_in_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_best[CLASSES].vld |-> r_state == S_ARG)
        else $error("argmax result outside argmax phase");

    a_feat_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_feat[CLASSES].vld |-> r_state == S_FEAT)
        else $error("feature leaves the row outside a feature run");

    a_win_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_best[CLASSES].vld |-> CLS_CW'(w_best[CLASSES].idx) < w_num)
        else $error("winning class beyond active classes");
`endif

endmodule

// ===== rtl/ldc_cell.sv =====
// ----------------------------------------------------------------------------
// ldc_cell
// One class of the classifier: weight memory, bias, label, multiply and
// saturating accumulate, and one step of the argmax.
// ----------------------------------------------------------------------------
module ldc_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic              i_be,
    input  ldc_pkg::t_load_bus i_load,
    input  ldc_pkg::t_feat_tok i_feat,
    output ldc_pkg::t_feat_tok o_feat,
    input  ldc_pkg::t_best_tok i_best,
    output ldc_pkg::t_best_tok o_best
);
    import ldc_pkg::*;

    localparam logic signed [ACC_W:0] SUM_MAX = (ACC_W+1)'((64'sd1 <<< (ACC_W-1)) - 1);
    localparam logic signed [ACC_W:0] SUM_MIN = -SUM_MAX - 1;

    logic signed [VAL_W-1:0]   mem [FEATURES];
    logic signed [BIAS_W-1:0]  r_bias;
    logic signed [LABEL_W-1:0] r_label;

    logic                      r_a_vld;
    logic                      r_a_seed;
    logic signed [VAL_W-1:0]   r_a_val;
    logic signed [VAL_W-1:0]   r_a_w;

    logic                      r_b_vld;
    logic                      r_b_seed;
    logic signed [PROD_W-1:0]  r_b_prod;

    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [ACC_W-1:0]   w_base;
    logic signed [ACC_W:0]     w_sum;

    t_feat_tok                 r_feat;
    t_best_tok                 r_best;
    t_best_tok                 n_best;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_load.addr] <= i_load.weight;
        end
        r_a_w <= mem[i_feat.addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_be) begin
            r_bias  <= i_load.bias;
            r_label <= i_load.label;
        end
        r_a_seed <= i_feat.seed;
        r_a_val  <= i_feat.value;
        r_b_seed <= r_a_seed;
        r_b_prod <= r_a_val * r_a_w;
    end

    always_comb begin
        w_base = r_b_seed ? ACC_W'(r_bias) : r_acc;
        w_sum  = (ACC_W+1)'(w_base) + (ACC_W+1)'(r_b_prod);
        if (w_sum > SUM_MAX) begin
            n_acc = ACC_W'(SUM_MAX);
        end else if (w_sum < SUM_MIN) begin
            n_acc = ACC_W'(SUM_MIN);
        end else begin
            n_acc = w_sum[ACC_W-1:0];
        end
    end

    always_comb begin
        n_best     = i_best;
        n_best.cur = i_best.cur + 1'b1;
        if (i_best.cur == '0 || (i_best.cur < i_best.num && r_acc > i_best.score)) begin
            n_best.idx   = i_best.cur[CLS_IW-1:0];
            n_best.score = r_acc;
            n_best.label = r_label;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_acc   <= '0;
            r_feat  <= '0;
            r_best  <= '0;
        end else begin
            r_a_vld <= i_feat.vld;
            r_b_vld <= r_a_vld;
            if (r_b_vld) begin
                r_acc <= n_acc;
            end
            r_feat <= i_feat;
            if (i_best.vld) begin
                r_best <= n_best;
            end else begin
                r_best.vld <= 1'b0;
            end
        end
    end

    assign o_feat = r_feat;
    assign o_best = r_best;

endmodule
